FILE: sv/hierarchical_bitmap_page_allocator_defines.svh
// Assertion macros shared by the page allocator RTL.
// No dependencies; define SYNTH to compile the assertions away.
`ifndef HIERARCHICAL_BITMAP_PAGE_ALLOCATOR_DEFINES_SVH
`define HIERARCHICAL_BITMAP_PAGE_ALLOCATOR_DEFINES_SVH

`ifndef SYNTH
// Consequent must hold in the same cycle as the antecedent.
`define HBPA_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("page allocator assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define HBPA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("page allocator assertion failed");
`else
`define HBPA_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define HBPA_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

FILE: sv/hbpa_pkg.sv
// Shared types and constants of the hierarchical bitmap page allocator.
// No dependencies; imported by every module of the block.
package hbpa_pkg;

  localparam int WORD_W     = 32;  // bitmap word width
  localparam int IDX_W      = 5;   // bit index inside one word
  localparam int PAGE_W     = 20;  // physical page number width
  localparam int ADDR_W     = 32;  // byte address width
  localparam int PAGE_SHIFT = 12;  // 4 KiB pages
  localparam int CNT_W      = 16;  // page count width
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 20;

  localparam logic [WORD_W-1:0] WORD_ONE = WORD_W'(1);

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BEGIN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_COUNT = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_OOM    = 2'd1,
    ST_DOUBLE = 2'd2,
    ST_RANGE  = 2'd3
  } status_t;

  typedef struct packed {
    logic              mode;
    logic              keep_resident;
    logic [PAGE_W-1:0] page_num;
  } req_t;

  typedef struct packed {
    logic [CNT_W-1:0]  free_pages;
    status_t           status;
    logic [ADDR_W-1:0] page_address;
  } rsp_t;

  typedef struct packed {
    logic [PAGE_W-1:0] first_page;
    logic [CNT_W-1:0]  size;
  } pool_cfg_t;

  typedef struct packed {
    logic idle;
    logic rsp_valid;
  } core_ctrl_t;

endpackage

FILE: sv/hbpa_lsb_unit.sv
// Lowest-set-bit encoder shared by every level of the bitmap walk.
// Depends on hbpa_pkg for the word and index widths.
module hbpa_lsb_unit (
  input  logic [hbpa_pkg::WORD_W-1:0] vec_i,
  output logic [hbpa_pkg::IDX_W-1:0]  idx_o,
  output logic                        zero_o
);
  import hbpa_pkg::*;

  logic [WORD_W-1:0] iso;

  // Isolate the lowest set bit, then OR-encode its position.
  assign iso    = vec_i & (~vec_i + WORD_ONE);
  assign zero_o = ~|vec_i;

  always_comb begin
    for (int b = 0; b < IDX_W; b++) begin
      idx_o[b] = 1'b0;
      for (int i = 0; i < WORD_W; i++) begin
        if (((i >> b) & 1) == 1) begin
          idx_o[b] = idx_o[b] | iso[i];
        end
      end
    end
  end

endmodule

FILE: sv/hbpa_core.sv
// Sequencer, bitmap memories and free counter of the page allocator.
// Depends on hbpa_pkg and hbpa_lsb_unit.
module hbpa_core #(
  parameter int PAGE_CAPACITY = 32768
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  reinit_i,
  input  hbpa_pkg::pool_cfg_t   pool_cfg_i,
  input  logic                  req_valid_i,
  input  hbpa_pkg::req_t        req_i,
  input  logic                  rsp_ready_i,
  output hbpa_pkg::core_ctrl_t  ctrl_o,
  output hbpa_pkg::rsp_t        rsp_o
);
  import hbpa_pkg::*;

  localparam int LEAF_WORDS = (PAGE_CAPACITY + WORD_W - 1) / WORD_W;
  localparam int L2_WORDS   = (LEAF_WORDS + WORD_W - 1) / WORD_W;
  localparam int L1_WORDS   = (L2_WORDS + WORD_W - 1) / WORD_W;
  localparam int LEAF_AW    = (LEAF_WORDS > 1) ? $clog2(LEAF_WORDS) : 1;
  localparam int L2_AW      = (L2_WORDS > 1) ? $clog2(L2_WORDS) : 1;
  localparam int L1_AW      = (L1_WORDS > 1) ? $clog2(L1_WORDS) : 1;

  localparam logic [IDX_W:0]     L1_LIM   = (IDX_W + 1)'(L1_WORDS);
  localparam logic [2*IDX_W:0]   L2_LIM   = (2 * IDX_W + 1)'(L2_WORDS);
  localparam logic [3*IDX_W:0]   LEAF_LIM = (3 * IDX_W + 1)'(LEAF_WORDS);
  localparam logic [LEAF_AW:0]   L2_CLR   = (LEAF_AW + 1)'(L2_WORDS);
  localparam logic [LEAF_AW:0]   L1_CLR   = (LEAF_AW + 1)'(L1_WORDS);
  localparam logic [LEAF_AW-1:0] CLR_LAST = LEAF_AW'(LEAF_WORDS - 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_A_TOP, S_A_L1, S_A_L2, S_A_LEAF, S_A_COMMIT,
    S_F_SUB, S_F_RNG, S_F_RMW, S_DONE
  } state_t;

  state_t             state_r;
  logic [LEAF_AW-1:0] clr_cnt_r;
  logic [WORD_W-1:0]  top_r;
  logic [CNT_W-1:0]   free_count_r;
  logic [PAGE_W-1:0]  page_r;
  logic [PAGE_W-1:0]  pnum_r;
  logic               keep_r;
  logic               borrow_r;
  status_t            status_r;
  logic [ADDR_W-1:0]  addr_r;

  // Memories: read data is registered and held between reads.
  logic [WORD_W-1:0] l1_mem   [L1_WORDS];
  logic [WORD_W-1:0] l2_mem   [L2_WORDS];
  logic [WORD_W-1:0] leaf_mem [LEAF_WORDS];
  logic [WORD_W-1:0] res_mem  [LEAF_WORDS];
  logic [WORD_W-1:0] l1_rd_r, l2_rd_r, leaf_rd_r, res_rd_r;

  logic               l1_we, l2_we, leaf_we, res_we;
  logic               l1_re, l2_re, leaf_re;
  logic [L1_AW-1:0]   l1_wa, l1_ra;
  logic [L2_AW-1:0]   l2_wa, l2_ra;
  logic [LEAF_AW-1:0] leaf_wa, leaf_ra;
  logic [WORD_W-1:0]  l1_wd, l2_wd, leaf_wd, res_wd;

  logic [WORD_W-1:0]   lsb_in;
  logic [IDX_W-1:0]    lsb_idx;
  logic                lsb_zero;
  logic [IDX_W-1:0]    i1_idx, l2_idx, l3_idx, lp_idx;
  logic [2*IDX_W-1:0]  i2_cur;
  logic [3*IDX_W-1:0]  i3_cur;
  logic [WORD_W-1:0]   bit_lp, bit_l3, bit_l2;
  logic [WORD_W-1:0]   leaf_new, l2_new, l1_new;
  logic [PAGE_W-1:0]   size_ext, page_sum;
  logic [PAGE_W:0]     diff;
  logic                alloc_ok, dbl, commit, release_ok, clearing;

  hbpa_lsb_unit u_lsb (
    .vec_i  (lsb_in),
    .idx_o  (lsb_idx),
    .zero_o (lsb_zero)
  );

  // The shared encoder looks at whichever word the walk has just read.
  always_comb begin
    case (state_r)
      S_A_L1:   lsb_in = l1_rd_r;
      S_A_L2:   lsb_in = l2_rd_r;
      S_A_LEAF: lsb_in = leaf_rd_r;
      default:  lsb_in = top_r;
    endcase
  end

  assign i1_idx = page_r[3*IDX_W +: IDX_W];
  assign l2_idx = page_r[2*IDX_W +: IDX_W];
  assign l3_idx = page_r[IDX_W +: IDX_W];
  assign lp_idx = page_r[0 +: IDX_W];
  assign i2_cur = {i1_idx, lsb_idx};
  assign i3_cur = {i1_idx, l2_idx, lsb_idx};

  assign bit_lp   = WORD_ONE << lp_idx;
  assign bit_l3   = WORD_ONE << l3_idx;
  assign bit_l2   = WORD_ONE << l2_idx;
  assign leaf_new = leaf_rd_r & ~bit_lp;
  assign l2_new   = l2_rd_r & ~bit_l3;
  assign l1_new   = l1_rd_r & ~bit_l2;

  assign size_ext   = {{(PAGE_W - CNT_W){1'b0}}, pool_cfg_i.size};
  assign page_sum   = pool_cfg_i.first_page + page_r;
  assign diff       = {1'b0, pnum_r} - {1'b0, pool_cfg_i.first_page};
  assign alloc_ok   = page_r < size_ext;
  assign dbl        = leaf_rd_r[lp_idx];
  assign clearing   = (state_r == S_CLEAR);
  assign commit     = (state_r == S_A_COMMIT) && alloc_ok;
  assign release_ok = (state_r == S_F_RMW) && !dbl;

  // Read ports.
  assign l1_re   = (state_r == S_A_TOP) || (state_r == S_F_RNG);
  assign l2_re   = (state_r == S_A_L1) || (state_r == S_F_RNG);
  assign leaf_re = (state_r == S_A_L2) || (state_r == S_F_RNG);
  assign l1_ra   = (state_r == S_A_TOP) ? lsb_idx[L1_AW-1:0] : page_r[3*IDX_W +: L1_AW];
  assign l2_ra   = (state_r == S_A_L1) ? i2_cur[L2_AW-1:0] : page_r[2*IDX_W +: L2_AW];
  assign leaf_ra = (state_r == S_A_L2) ? i3_cur[LEAF_AW-1:0] : page_r[IDX_W +: LEAF_AW];

  // Write ports: clearing sweep, allocation commit or release.
  assign leaf_we = clearing || commit || release_ok;
  assign leaf_wa = clearing ? clr_cnt_r : page_r[IDX_W +: LEAF_AW];
  assign leaf_wd = clearing ? '1 : (commit ? leaf_new : (leaf_rd_r | bit_lp));

  assign l2_we = (clearing && ({1'b0, clr_cnt_r} < L2_CLR)) ||
                 (commit && (leaf_new == '0)) || release_ok;
  assign l2_wa = clearing ? clr_cnt_r[L2_AW-1:0] : page_r[2*IDX_W +: L2_AW];
  assign l2_wd = clearing ? '1 : (commit ? l2_new : (l2_rd_r | bit_l3));

  assign l1_we = (clearing && ({1'b0, clr_cnt_r} < L1_CLR)) ||
                 (commit && (leaf_new == '0) && (l2_new == '0)) || release_ok;
  assign l1_wa = clearing ? clr_cnt_r[L1_AW-1:0] : page_r[3*IDX_W +: L1_AW];
  assign l1_wd = clearing ? '1 : (commit ? l1_new : (l1_rd_r | bit_l2));

  assign res_we = commit;
  assign res_wd = keep_r ? (res_rd_r | bit_lp) : (res_rd_r & ~bit_lp);

  always_ff @(posedge clk) begin
    if (l1_we) l1_mem[l1_wa] <= l1_wd;
    if (l1_re) l1_rd_r <= l1_mem[l1_ra];
  end

  always_ff @(posedge clk) begin
    if (l2_we) l2_mem[l2_wa] <= l2_wd;
    if (l2_re) l2_rd_r <= l2_mem[l2_ra];
  end

  always_ff @(posedge clk) begin
    if (leaf_we) leaf_mem[leaf_wa] <= leaf_wd;
    if (leaf_re) leaf_rd_r <= leaf_mem[leaf_ra];
  end

  always_ff @(posedge clk) begin
    if (res_we) res_mem[leaf_wa] <= res_wd;
    if (leaf_re) res_rd_r <= res_mem[leaf_ra];
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_cnt_r    <= '0;
      top_r        <= '1;
      free_count_r <= '0;
    end else if (reinit_i) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      unique case (state_r)
        S_CLEAR: begin
          top_r        <= '1;
          free_count_r <= pool_cfg_i.size;
          clr_cnt_r    <= clr_cnt_r + LEAF_AW'(1);
          if (clr_cnt_r == CLR_LAST) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid_i) begin
            keep_r  <= req_i.keep_resident;
            pnum_r  <= req_i.page_num;
            addr_r  <= '0;
            state_r <= (req_i.mode == MODE_FREE) ? S_F_SUB : S_A_TOP;
          end
        end
        S_A_TOP: begin
          if ((free_count_r == '0) || lsb_zero || ({1'b0, lsb_idx} >= L1_LIM)) begin
            status_r <= ST_OOM;
            state_r  <= S_DONE;
          end else begin
            page_r[3*IDX_W +: IDX_W] <= lsb_idx;
            state_r <= S_A_L1;
          end
        end
        S_A_L1: begin
          if (lsb_zero || ({1'b0, i2_cur} >= L2_LIM)) begin
            status_r <= ST_OOM;
            state_r  <= S_DONE;
          end else begin
            page_r[2*IDX_W +: IDX_W] <= lsb_idx;
            state_r <= S_A_L2;
          end
        end
        S_A_L2: begin
          if (lsb_zero || ({1'b0, i3_cur} >= LEAF_LIM)) begin
            status_r <= ST_OOM;
            state_r  <= S_DONE;
          end else begin
            page_r[IDX_W +: IDX_W] <= lsb_idx;
            state_r <= S_A_LEAF;
          end
        end
        S_A_LEAF: begin
          if (lsb_zero) begin
            status_r <= ST_OOM;
            state_r  <= S_DONE;
          end else begin
            page_r[0 +: IDX_W] <= lsb_idx;
            state_r <= S_A_COMMIT;
          end
        end
        S_A_COMMIT: begin
          if (!alloc_ok) begin
            status_r <= ST_OOM;
          end else begin
            status_r     <= ST_OK;
            free_count_r <= free_count_r - CNT_W'(1);
            addr_r       <= {page_sum, {PAGE_SHIFT{1'b0}}};
            if ((leaf_new == '0) && (l2_new == '0) && (l1_new == '0)) begin
              top_r[i1_idx] <= 1'b0;
            end
          end
          state_r <= S_DONE;
        end
        S_F_SUB: begin
          page_r   <= diff[PAGE_W-1:0];
          borrow_r <= diff[PAGE_W];
          state_r  <= S_F_RNG;
        end
        S_F_RNG: begin
          if (borrow_r || !alloc_ok) begin
            status_r <= ST_RANGE;
            state_r  <= S_DONE;
          end else begin
            state_r <= S_F_RMW;
          end
        end
        S_F_RMW: begin
          if (dbl) begin
            status_r <= ST_DOUBLE;
          end else begin
            status_r      <= ST_OK;
            top_r[i1_idx] <= 1'b1;
            if (free_count_r < pool_cfg_i.size) begin
              free_count_r <= free_count_r + CNT_W'(1);
            end
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (rsp_ready_i) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign ctrl_o.idle      = (state_r == S_IDLE);
  assign ctrl_o.rsp_valid = (state_r == S_DONE);

  assign rsp_o.page_address = addr_r;
  assign rsp_o.status       = status_r;
  assign rsp_o.free_pages   = free_count_r;

endmodule

FILE: sv/hierarchical_bitmap_page_allocator.sv
// Top level of the hierarchical bitmap page allocator; it depends on hbpa_pkg, hbpa_core,
// hbpa_lsb_unit and the assertion macro header. The block hands out and takes back 4 KiB
// physical pages from a pool tracked by a four-level bitmap (1 = free). An input item with
// tuser mode 0 allocates the lowest free page and returns its byte address; mode 1 frees the
// page whose byte address is in tdata. Each item yields exactly one result item carrying the
// address (zero unless an allocation succeeded), a status (ok, out of memory, page already
// free, address outside pool) and the free count after the request. Items are handled one at
// a time, and an early error ends the walk sooner. An allocation follows a chain of dependent
// reads guided by the top word through the level-one, level-two and leaf bitmap memories,
// each word decoded by one shared lowest-set-bit encoder. A finished result sits in an
// output register, so the next item is accepted while it waits. After reset, and after
// every write of pool_page_count, the block sweeps the bitmap memories back to all ones,
// stepping through LEAF_WORDS = ceil(PAGE_CAPACITY / 32) leaf addresses (1024 by default),
// and accepts no item meanwhile; configuration writes are always accepted. Configuration
// must only be written while the block is idle.

`include "hierarchical_bitmap_page_allocator_defines.svh"

module hierarchical_bitmap_page_allocator #(
  parameter int PAGE_CAPACITY = 32768
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Request channel.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [31:0]                     in_tdata,   // [31:0] free_address
  input  logic [1:0]                      in_tuser,   // [0] mode, [1] keep_resident
  // Result channel.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [55:0]                     out_tdata,  // [31:0] page_address, [33:32] status,
                                                      // [49:34] free_pages, [55:50] zero
  // Configuration write channel.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [hbpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hbpa_pkg::CFG_DATA_W-1:0] cfg_data
);
  import hbpa_pkg::*;

  // The effective pool size is the written count clipped to the bitmap capacity.
  localparam int CAP_CLIP = (PAGE_CAPACITY > 65535) ? 65535 : PAGE_CAPACITY;
  localparam logic [CNT_W-1:0] CAP_LIM = CNT_W'(CAP_CLIP);

  logic [PAGE_W-1:0] pool_begin_r;
  logic [CNT_W-1:0]  pool_count_r;
  logic              cfg_take;
  logic              reinit;
  pool_cfg_t         pool_cfg;
  req_t              req;
  rsp_t              rsp;
  core_ctrl_t        ctrl;
  logic              rsp_ready;
  logic              rsp_take;
  logic              out_valid_r;
  rsp_t              out_data_r;

  // Configuration registers. Writing the page count restarts the clearing sweep.
  assign cfg_ready = 1'b1;
  assign cfg_take  = cfg_valid && cfg_ready;
  assign reinit    = cfg_take && (cfg_index == CFG_POOL_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_begin_r <= PAGE_W'(1024);
      pool_count_r <= CNT_W'(32768);
    end else if (cfg_take) begin
      unique case (cfg_index)
        CFG_POOL_BEGIN: pool_begin_r <= cfg_data[PAGE_W-1:0];
        CFG_POOL_COUNT: pool_count_r <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign pool_cfg.first_page = pool_begin_r;
  assign pool_cfg.size       = (pool_count_r > CAP_LIM) ? CAP_LIM : pool_count_r;

  // The core accepts a request only when its sequencer is idle.
  assign in_tready         = ctrl.idle;
  assign req.mode          = in_tuser[0];
  assign req.keep_resident = in_tuser[1];
  assign req.page_num      = in_tdata[ADDR_W-1:PAGE_SHIFT];

  hbpa_core #(
    .PAGE_CAPACITY (PAGE_CAPACITY)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .reinit_i    (reinit),
    .pool_cfg_i  (pool_cfg),
    .req_valid_i (in_tvalid && in_tready),
    .req_i       (req),
    .rsp_ready_i (rsp_ready),
    .ctrl_o      (ctrl),
    .rsp_o       (rsp)
  );

  // Output register: the core hands over its result once the slot is free or emptying.
  assign rsp_ready = !out_valid_r || out_tready;
  assign rsp_take  = ctrl.rsp_valid && rsp_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rsp_take) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_take) begin
      out_data_r <= rsp;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_data_r.free_pages, out_data_r.status,
                       out_data_r.page_address};

  // An accepted item always takes the sequencer out of its idle state.
  `HBPA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready)
  // Every failed request reports a zero address.
  `HBPA_ASSERT_SAME(a_err_zero_addr, clk, rst_n, ctrl.rsp_valid && (rsp.status != ST_OK), rsp.page_address == '0)
  // A result handed over by the core is presented on the next cycle.
  `HBPA_ASSERT_NEXT(a_rsp_lands, clk, rst_n, rsp_take, out_tvalid)

endmodule
